/* design/iaf_pkg.sv */
package iaf_pkg;

  // format selector codes
  localparam logic [1:0] FMT_SDEC  = 2'd0;
  localparam logic [1:0] FMT_UDEC  = 2'd1;
  localparam logic [1:0] FMT_HEX32 = 2'd2;
  localparam logic [1:0] FMT_HEX64 = 2'd3;

  // ascii codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_A     = 8'h61;

  localparam int DEC_DIGITS = 10;
  localparam int CONV_STEPS = 32;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] value;
  } req_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } rsp_t;

  // which character the datapath shows
  typedef enum logic [1:0] {
    CSEL_MINUS,
    CSEL_ZERO,
    CSEL_X,
    CSEL_DIGIT
  } csel_t;

  typedef struct packed {
    logic  load;
    logic  conv_step;
    logic  prep;
    logic  emit_shift;
    csel_t csel;
  } iaf_cmd_t;

  typedef struct packed {
    logic neg;
    logic conv_done;
    logic last;
  } iaf_sts_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] code;
    if (nib < 4'd10) begin
      code = CH_ZERO + {4'b0, nib};
    end else begin
      code = CH_A + {4'b0, nib - 4'd10};
    end
    return code;
  endfunction

endpackage

/* design/iaf_datapath.sv */
module iaf_datapath
  import iaf_pkg::*;
(
  input  logic     clk,
  input  req_t     in_data,
  input  iaf_cmd_t cmd,
  output iaf_sts_t sts,
  output rsp_t     out_data
);

  logic [63:0]                  shreg;
  logic [DEC_DIGITS-1:0][3:0]   bcd;
  logic [DEC_DIGITS-1:0][3:0]   adj;
  logic [DEC_DIGITS*4:0]        bcd_shift;
  logic [4:0]                   step;
  logic [3:0]                   cnt;
  logic [3:0]                   msd;
  logic                         neg;
  logic                         is_hex;
  logic [31:0]                  lo;
  logic [31:0]                  mag;
  logic                         lo_neg;
  logic [3:0]                   nib;

  assign lo     = in_data.value[31:0];
  assign lo_neg = (in_data.req_type == FMT_SDEC) && lo[31];
  assign mag    = lo_neg ? (32'd0 - lo) : lo;

  // add-3 correction before each shift
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
  end

  // corrected digits shifted left by one, next binary bit entering at the bottom
  assign bcd_shift = {adj, shreg[63]};

  // most significant nonzero digit, zero prints one digit
  always_comb begin
    msd = '0;
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd[i] != 4'd0) msd = 4'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg    <= lo_neg;
      is_hex <= (in_data.req_type == FMT_HEX32) || (in_data.req_type == FMT_HEX64);
      bcd    <= '0;
      step   <= '0;
      unique case (in_data.req_type)
        FMT_HEX64: begin
          shreg <= in_data.value;
          cnt   <= 4'd15;
        end
        FMT_HEX32: begin
          shreg <= {lo, 32'd0};
          cnt   <= 4'd7;
        end
        default: begin
          shreg <= {mag, 32'd0};
          cnt   <= 4'd7;
        end
      endcase
    end else if (cmd.conv_step) begin
      bcd   <= bcd_shift[DEC_DIGITS*4-1:0];
      shreg <= {shreg[62:0], 1'b0};
      step  <= step + 5'd1;
    end else if (cmd.prep) begin
      cnt <= msd;
    end else if (cmd.emit_shift) begin
      shreg <= {shreg[59:0], 4'd0};
      cnt   <= cnt - 4'd1;
    end
  end

  assign sts.neg       = neg;
  assign sts.conv_done = (step == 5'(CONV_STEPS - 1));
  assign sts.last      = (cnt == 4'd0);

  assign nib = is_hex ? shreg[63:60] : bcd[cnt];

  always_comb begin
    case (cmd.csel)
      CSEL_MINUS: out_data.char_code = CH_MINUS;
      CSEL_ZERO:  out_data.char_code = CH_ZERO;
      CSEL_X:     out_data.char_code = CH_X;
      default:    out_data.char_code = hex_char(nib);
    endcase
    out_data.last_char = (cmd.csel == CSEL_DIGIT) && (cnt == 4'd0);
  end

endmodule

/* design/iaf_ctrl.sv */
module iaf_ctrl
  import iaf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] req_type,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  iaf_sts_t   sts,
  output iaf_cmd_t   cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CONV   = 7'b0000010,
    S_PREP   = 7'b0000100,
    S_MINUS  = 7'b0001000,
    S_PFX0   = 7'b0010000,
    S_PFXX   = 7'b0100000,
    S_DIGITS = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   in_xfer;
  logic   out_xfer;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_MINUS) || (state == S_PFX0) ||
                     (state == S_PFXX) || (state == S_DIGITS);
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;

  always_comb begin
    state_next     = state;
    cmd.load       = 1'b0;
    cmd.conv_step  = 1'b0;
    cmd.prep       = 1'b0;
    cmd.emit_shift = 1'b0;
    cmd.csel       = CSEL_DIGIT;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          cmd.load = 1'b1;
          if ((req_type == FMT_HEX32) || (req_type == FMT_HEX64)) begin
            state_next = S_PFX0;
          end else begin
            state_next = S_CONV;
          end
        end
      end
      S_CONV: begin
        cmd.conv_step = 1'b1;
        if (sts.conv_done) state_next = S_PREP;
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = sts.neg ? S_MINUS : S_DIGITS;
      end
      S_MINUS: begin
        cmd.csel = CSEL_MINUS;
        if (out_xfer) state_next = S_DIGITS;
      end
      S_PFX0: begin
        cmd.csel = CSEL_ZERO;
        if (out_xfer) state_next = S_PFXX;
      end
      S_PFXX: begin
        cmd.csel = CSEL_X;
        if (out_xfer) state_next = S_DIGITS;
      end
      S_DIGITS: begin
        if (out_xfer) begin
          if (sts.last) begin
            state_next = S_IDLE;
          end else begin
            cmd.emit_shift = 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* design/integer_to_ascii_formatter.sv */
// channel   dir  handshake              payload
// in        in   in_valid / in_ready    req_t   {req_type, value}
// out       out  out_valid / out_ready  rsp_t   {char_code, last_char}
//
// sequence: hex formats load, then give one character per cycle while out_ready
//   is high (10 chars for hex32, 18 for hex64); decimal formats load, run the
//   double-dabble shift steps and a digit-count step, then give 1 to 11 chars
// the 32-step shift-add-3 loop in the datapath does the decimal conversion
// reset: rst is synchronous, returns the controller to idle; no data cleared
// stalls: a character stays on out_data while out_ready is low; in_ready
//   rises again the cycle after the last character's transfer
module integer_to_ascii_formatter
  import iaf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_data
);

  iaf_cmd_t cmd;
  iaf_sts_t sts;

  // sequencer: load, convert decimal values, then walk through the characters
  iaf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .req_type  (in_data.req_type),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // shift register, bcd digits and digit counter
  iaf_datapath u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

`ifndef SYNTHESIS
  // one item at a time: never taking input while a character is shown
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while output valid");

  // a hex item starts its output with '0' right away
  a_hex_prefix: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready &&
     ((in_data.req_type == FMT_HEX32) || (in_data.req_type == FMT_HEX64)))
    |=> (out_valid && out_data.char_code == CH_ZERO && !out_data.last_char))
    else $error("hex prefix missing");

  // a decimal item first runs the conversion
  a_dec_conv: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready &&
     ((in_data.req_type == FMT_SDEC) || (in_data.req_type == FMT_UDEC)))
    |=> !out_valid)
    else $error("decimal output before conversion");

  // the last character frees the block
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_data.last_char) |=> in_ready)
    else $error("not idle after last character");
`endif

endmodule
